// ===== rtl/core/swma_pkg.sv =====
// shared types and constants for the stack with middle access
// action and status codes, controller/datapath command and status structs
// no dependencies
package swma_pkg;

  localparam int WORD_W        = 32;
  localparam int DEFAULT_DEPTH = 16;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_MID  = 2'd2,
    ACT_DEL  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  // controller to datapath
  typedef struct packed {
    logic  cap_item;   // latch the accepted request
    logic  set_res;    // clear result word and set status code
    stat_t res_stat;
    logic  push_wr;    // write value at top, raise count
    logic  pop_rd;     // read top entry, lower count
    logic  mid_rd;     // read middle entry, index <= middle
    logic  cap_rdata;  // result word <= read data
    logic  dec_count;
    logic  sh_rd;      // read entry above the index
    logic  sh_wr;      // write read data at index, step index
    logic  load_out;   // move result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    act_t act;
    logic empty;
    logic full;
    logic shift_more;
  } sts_t;

endpackage

// ===== rtl/core/swma_ctrl.sv =====
// request sequencer for the stack with middle access
// drives datapath commands and the stream handshakes; uses swma_pkg
module swma_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  swma_pkg::sts_t sts,
  output swma_pkg::cmd_t cmd
);
  import swma_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.res_stat  = ST_OK;
    state_nxt     = state_r;
    in_tready_nxt = in_tready_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.cap_item  = 1'b1;
          in_tready_nxt = 1'b0;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_res = 1'b1;
        state_nxt   = S_DONE;
        if (sts.act == ACT_PUSH) begin
          if (sts.full) begin
            cmd.res_stat = ST_FULL;
          end else begin
            cmd.push_wr = 1'b1;
          end
        end else if (sts.empty) begin
          cmd.res_stat = ST_EMPTY;
        end else begin
          state_nxt = S_RD_WAIT;
          if (sts.act == ACT_POP) begin
            cmd.pop_rd = 1'b1;
          end else begin
            cmd.mid_rd = 1'b1;
          end
        end
      end
      S_RD_WAIT: begin
        cmd.cap_rdata = 1'b1;
        if (sts.act == ACT_DEL) begin
          // lower count first so the shift runs while index < count
          cmd.dec_count = 1'b1;
          state_nxt     = S_SH_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SH_RD: begin
        if (sts.shift_more) begin
          cmd.sh_rd = 1'b1;
          state_nxt = S_SH_WR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SH_WR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SH_RD;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          in_tready_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        in_tready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= in_tready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/core/swma_dp.sv =====
// datapath of the stack with middle access: entry memory, count, index,
// result and output registers; uses swma_pkg
module swma_dp #(
  parameter int DEPTH = swma_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  swma_pkg::cmd_t                    cmd,
  output swma_pkg::sts_t                    sts,
  input  logic [1:0]                        in_action,
  input  logic signed [swma_pkg::WORD_W-1:0] in_value,
  output logic signed [swma_pkg::WORD_W-1:0] out_value,
  output logic [1:0]                        out_status
);
  import swma_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_addr;

  act_t              action_r;
  logic [WORD_W-1:0] value_r;
  logic [CW-1:0]     count_r;
  logic [AW-1:0]     idx_r;
  logic [WORD_W-1:0] res_r;
  stat_t             stat_r;
  logic [WORD_W-1:0] out_value_r;
  stat_t             out_stat_r;

  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_half;
  logic [AW-1:0]     mid_idx;
  logic [AW-1:0]     idx_p1;

  assign cnt_m1   = count_r - CW'(1);
  assign cnt_half = cnt_m1 >> 1;
  assign mid_idx  = cnt_half[AW-1:0];
  assign idx_p1   = idx_r + AW'(1);

  always_comb begin
    rd_addr = mid_idx;
    if (cmd.pop_rd) begin
      rd_addr = cnt_m1[AW-1:0];
    end else if (cmd.sh_rd) begin
      rd_addr = idx_p1;
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem[count_r[AW-1:0]] <= value_r;
    end else if (cmd.sh_wr) begin
      mem[idx_r] <= rd_data_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.push_wr) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.pop_rd || cmd.dec_count) begin
      count_r <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      action_r <= act_t'(in_action);
      value_r  <= in_value;
    end
    if (cmd.mid_rd) begin
      idx_r <= mid_idx;
    end else if (cmd.sh_wr) begin
      idx_r <= idx_p1;
    end
    if (cmd.set_res) begin
      res_r  <= '0;
      stat_r <= cmd.res_stat;
    end else if (cmd.cap_rdata) begin
      res_r <= rd_data_r;
    end
    if (cmd.load_out) begin
      out_value_r <= res_r;
      out_stat_r  <= stat_r;
    end
  end

  assign sts.act        = action_r;
  assign sts.empty      = (count_r == '0);
  assign sts.full       = (count_r == CW'(DEPTH));
  assign sts.shift_more = (CW'(idx_r) < count_r);

  assign out_value  = out_value_r;
  assign out_status = out_stat_r;

endmodule

// ===== rtl/core/stack_with_middle_access_core.sv =====
// top level of the bounded stack with push, pop, read-middle, delete-middle
// joins swma_ctrl and swma_dp; uses swma_pkg
// one request at a time: push or an error result passes the execute and done
// states, pop and read-middle add a read-wait state, and delete-middle then
// shifts each entry above the middle down, a read state then a write state each.
// input ready rises again as the result enters the output register.
// synchronous active-low reset empties the stack; entry memory is not cleared.
module stack_with_middle_access_core #(
  parameter int DEPTH = swma_pkg::DEFAULT_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic signed [swma_pkg::WORD_W-1:0] in_tdata,  // [31:0] push_value
  input  logic [1:0]                         in_tuser,  // [1:0] action
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic signed [swma_pkg::WORD_W-1:0] out_tdata, // [31:0] result_value
  output logic [1:0]                         out_tuser  // [1:0] status
);
  import swma_pkg::*;

  cmd_t cmd;
  sts_t sts;

  swma_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  swma_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (in_tuser),
    .in_value   (in_tdata),
    .out_value  (out_tdata),
    .out_status (out_tuser)
  );

endmodule

// ===== rtl/core/swma_checker.sv =====
// port-level checks for stack_with_middle_access_core
// bound to the top level below; uses swma_pkg
module swma_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic signed [swma_pkg::WORD_W-1:0] out_tdata,
  input logic [1:0]                         out_tuser
);
  import swma_pkg::*;

  // one request in flight: ready drops after each input transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a request is in flight");

  // error and push-full results carry a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata == '0)
    else $error("non-zero word with an error status");

  a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_EMPTY || out_tuser == ST_FULL))
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind stack_with_middle_access_core swma_checker u_swma_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
